// File: hw/rtl/lru_entry_pool_with_pins_defines.svh
// Assertion macros used by the checker of the entry pool.
`ifndef LRU_ENTRY_POOL_WITH_PINS_DEFINES_SVH
`define LRU_ENTRY_POOL_WITH_PINS_DEFINES_SVH

// Check cons in the cycle after ante.
`define LRUPOOL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Check cons in the same cycle as ante.
`define LRUPOOL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lrupool_pkg.sv
`timescale 1ns / 1ps
package lrupool_pkg;

  localparam logic OP_TAKE = 1'b0;
  localparam logic OP_DROP = 1'b1;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_FREE = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [3:0] entry_index;
  } in_t;

  typedef struct packed {
    logic [3:0] granted_index;
    logic       status;
  } out_t;

  typedef struct packed {
    logic       take;
    logic       drop;
    logic [3:0] idx;
  } cell_ctl_t;

endpackage

// File: hw/rtl/lru_entry_pool_with_pins.sv
`timescale 1ns / 1ps
// Pool of NUM_ENTRIES cache entries kept in recency order, each with an
// in-use mark.
// Input: a request is transferred at a rising edge with start high and
// busy low. operation TAKE hands out the least recent unused entry, marks
// it used and makes it most recent; operation DROP moves the named entry
// to the least recent end and clears its mark.
// Output: one result per request, on out_data for exactly one cycle with
// out_valid high, in the cycle after the request. status reports that a
// take found every entry in use (granted_index then reads zero).
// Throughput: one request every cycle; busy stays low. The whole update
// is done by a row of cells, one per recency position, that pass search
// flags along the row and shift entries to their neighbors.
// Reset: the order returns to entries 0 up to NUM_ENTRIES-1, all unused,
// and any pending result is discarded.
// The receiver cannot stall; a result not taken in its cycle is lost.
module lru_entry_pool_with_pins
  import lrupool_pkg::*;
#(
  parameter int NUM_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int IW = $clog2(NUM_ENTRIES);

  cell_ctl_t     ctl;
  logic          accept;
  logic [IW-1:0] entry_w [NUM_ENTRIES];
  logic          used_w  [NUM_ENTRIES];
  logic [IW-1:0] sel_w   [NUM_ENTRIES];
  logic          pre_w   [NUM_ENTRIES+1];
  logic          suf_w   [NUM_ENTRIES+1];
  logic [IW-1:0] take_entry;
  logic          found;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign ctl.take = accept && (in_data.operation == OP_TAKE);
  assign ctl.drop = accept && (in_data.operation == OP_DROP);
  assign ctl.idx  = in_data.entry_index;

  assign pre_w[0]           = 1'b0;
  assign suf_w[NUM_ENTRIES] = 1'b0;
  assign found              = pre_w[NUM_ENTRIES];

  always_comb begin
    take_entry = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      take_entry = take_entry | sel_w[i];
    end
  end

  for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
    logic [IW-1:0] l_entry, r_entry;
    logic          l_used, r_used;

    if (i == 0) begin : g_head
      assign l_entry = IW'(in_data.entry_index);
      assign l_used  = 1'b0;
    end else begin : g_mid_l
      assign l_entry = entry_w[i-1];
      assign l_used  = used_w[i-1];
    end

    if (i == NUM_ENTRIES - 1) begin : g_tail
      assign r_entry = take_entry;
      assign r_used  = 1'b1;
    end else begin : g_mid_r
      assign r_entry = entry_w[i+1];
      assign r_used  = used_w[i+1];
    end

    lrupool_cell #(
      .IW        (IW),
      .RST_ENTRY (IW'(i))
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_entry  (l_entry),
      .left_used   (l_used),
      .right_entry (r_entry),
      .right_used  (r_used),
      .pre_in      (pre_w[i]),
      .pre_out     (pre_w[i+1]),
      .suf_in      (suf_w[i+1]),
      .suf_out     (suf_w[i]),
      .sel_entry   (sel_w[i]),
      .cur_entry   (entry_w[i]),
      .cur_used    (used_w[i])
    );
  end

  always_comb begin
    out_valid_nxt = accept;
    out_nxt       = out_r;
    if (ctl.take) begin
      out_nxt.granted_index = 4'(take_entry);
      out_nxt.status        = found ? ST_OK : ST_NO_FREE;
    end else if (ctl.drop) begin
      out_nxt.granted_index = in_data.entry_index;
      out_nxt.status        = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/lrupool_cell.sv
`timescale 1ns / 1ps
module lrupool_cell
  import lrupool_pkg::*;
#(
  parameter int IW = 4,
  parameter logic [IW-1:0] RST_ENTRY = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cell_ctl_t     ctl,
  input  logic [IW-1:0] left_entry,
  input  logic          left_used,
  input  logic [IW-1:0] right_entry,
  input  logic          right_used,
  input  logic          pre_in,
  output logic          pre_out,
  input  logic          suf_in,
  output logic          suf_out,
  output logic [IW-1:0] sel_entry,
  output logic [IW-1:0] cur_entry,
  output logic          cur_used
);

  logic [IW-1:0] entry_r, entry_nxt;
  logic          used_r, used_nxt;
  logic          free_hit, idx_hit;

  assign free_hit  = !used_r;
  assign idx_hit   = ({4'b0, entry_r} == {{IW{1'b0}}, ctl.idx});
  assign pre_out   = pre_in | free_hit;
  assign suf_out   = suf_in | idx_hit;
  assign sel_entry = (free_hit && !pre_in) ? entry_r : '0;
  assign cur_entry = entry_r;
  assign cur_used  = used_r;

  always_comb begin
    entry_nxt = entry_r;
    used_nxt  = used_r;
    if (ctl.take && pre_out) begin
      entry_nxt = right_entry;
      used_nxt  = right_used;
    end else if (ctl.drop && suf_out) begin
      entry_nxt = left_entry;
      used_nxt  = left_used;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= RST_ENTRY;
      used_r  <= 1'b0;
    end else begin
      entry_r <= entry_nxt;
      used_r  <= used_nxt;
    end
  end

endmodule

// File: hw/rtl/lrupool_chk.sv
`timescale 1ns / 1ps
`include "lru_entry_pool_with_pins_defines.svh"
module lrupool_chk
  import lrupool_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  logic       xfer, drop_xfer, no_free;
  logic [3:0] in_idx;

  assign xfer      = start && !busy;
  assign drop_xfer = xfer && (in_data.operation == OP_DROP);
  assign no_free   = out_valid && (out_data.status == ST_NO_FREE);
  assign in_idx    = in_data.entry_index;

  `LRUPOOL_ASSERT_NEXT(a_result_follows, rst_n && xfer, out_valid, "missing result")
  `LRUPOOL_ASSERT_NEXT(a_no_spurious, !xfer, !out_valid, "result without request")
  `LRUPOOL_ASSERT_NOW(a_no_free_zero, no_free, out_data.granted_index == 4'd0, "no-free index")
  `LRUPOOL_ASSERT_NEXT(a_drop_echo, drop_xfer, out_data == {$past(in_idx), ST_OK}, "no echo")

endmodule

bind lru_entry_pool_with_pins lrupool_chk u_lrupool_chk (.*);

// File: verif/tb_lru_entry_pool_with_pins.sv
`timescale 1ns / 1ps
module tb_lru_entry_pool_with_pins;
  import lrupool_pkg::*;

  localparam int POOL_SIZE = 16;
  localparam int CALM_TAIL = 60;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;

  in_t pending_reqs[$];
  out_t grant_q[$];
  logic [3:0] order_list[POOL_SIZE];
  logic [POOL_SIZE-1:0] pinned;
  logic sent = 1'b0;
  int gap_left = 0;
  int fail_count = 0;
  int cycle_count = 0;

  lru_entry_pool_with_pins #(
    .NUM_ENTRIES(POOL_SIZE)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic void pool_clear();
    for (int i = 0; i < POOL_SIZE; i++) begin
      order_list[i] = 4'(i);
    end
    pinned = '0;
  endfunction

  function automatic out_t pool_step(in_t req);
    out_t res;
    int hit;
    logic [3:0] ent;
    res.granted_index = '0;
    res.status = ST_OK;
    hit = -1;
    if (req.operation == OP_TAKE) begin
      for (int p = 0; p < POOL_SIZE; p++) begin
        if (hit < 0 && !pinned[order_list[p]]) hit = p;
      end
      if (hit < 0) begin
        res.status = ST_NO_FREE;
      end else begin
        ent = order_list[hit];
        pinned[ent] = 1'b1;
        for (int p = hit; p < POOL_SIZE - 1; p++) begin
          order_list[p] = order_list[p + 1];
        end
        order_list[POOL_SIZE - 1] = ent;
        res.granted_index = ent;
      end
    end else begin
      res.granted_index = req.entry_index;
      for (int p = 0; p < POOL_SIZE; p++) begin
        if (hit < 0 && order_list[p] == req.entry_index) hit = p;
      end
      if (hit >= 0) begin
        for (int p = hit; p > 0; p--) begin
          order_list[p] = order_list[p - 1];
        end
        order_list[0] = req.entry_index;
        pinned[req.entry_index] = 1'b0;
      end
    end
    return res;
  endfunction

  task automatic add_req(logic op, logic [3:0] idx);
    in_t req;
    req.operation = op;
    req.entry_index = idx;
    pending_reqs = {pending_reqs, req};
  endtask

  // drive on the falling edge; hold a request until it transfers
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !sent) begin
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_reqs.size() == 0) begin
      start <= 1'b0;
    end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
      gap_left <= $urandom_range(0, 11);
      start <= 1'b0;
    end else begin
      in_data <= pending_reqs.pop_front();
      start <= 1'b1;
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      sent <= 1'b0;
    end else begin
      if (out_valid) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual idx=%0d status=%0d",
                   $time, out_data.granted_index, out_data.status);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (out_data.granted_index !== want.granted_index) begin
            $display("%0t: granted_index mismatch: expected %0d, actual %0d",
                     $time, want.granted_index, out_data.granted_index);
            fail_count++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_data.status);
            fail_count++;
          end
        end
      end
      if (start && !busy) grant_q = {grant_q, pool_step(in_data)};
      sent <= start && !busy;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_lru_entry_pool_with_pins: FAIL");
      $finish;
    end
  end

  initial begin
    int take_pct;
    pool_clear();
    for (int i = 0; i < POOL_SIZE + 1; i++) begin
      add_req(OP_TAKE, 4'(i));
    end
    add_req(OP_DROP, 4'd0);
    add_req(OP_DROP, 4'd15);
    add_req(OP_DROP, 4'd0);
    add_req(OP_TAKE, 4'd15);
    add_req(OP_TAKE, 4'd0);
    add_req(OP_TAKE, 4'd7);
    add_req(OP_DROP, 4'd10);
    for (int chunk = 0; chunk < 8; chunk++) begin
      take_pct = $urandom_range(15, 85);
      for (int i = 0; i < 50; i++) begin
        add_req(($urandom_range(0, 99) < take_pct) ? OP_TAKE : OP_DROP,
                4'($urandom_range(0, 15)));
      end
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (pending_reqs.size() != 0 || start || grant_q.size() != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && grant_q.size() == 0) begin
      $display("tb_lru_entry_pool_with_pins: PASS");
    end else begin
      $display("tb_lru_entry_pool_with_pins: FAIL");
    end
    $finish;
  end

endmodule
